// File: hdl/lrg_pkg.sv
// Shared types, constants and helper functions for the ray grid generator.
`timescale 1ns / 1ps
package lrg_pkg;

  localparam int MAX_COLUMNS  = 1024;
  localparam int MAX_RINGS    = 128;
  localparam int CORDIC_ITERS = 30;

  localparam logic [10:0] AZ_COUNT_MAX   = 11'd1024;
  localparam logic [7:0]  EL_COUNT_MAX   = 8'd128;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_AZ_COUNT  = 3'd0;
  localparam logic [2:0] CFG_EL_COUNT  = 3'd1;
  localparam logic [2:0] CFG_AZ_START  = 3'd2;
  localparam logic [2:0] CFG_AZ_STEP   = 3'd3;
  localparam logic [2:0] CFG_EL_MIN    = 3'd4;
  localparam logic [2:0] CFG_EL_STEP   = 3'd5;
  localparam logic [2:0] CFG_TIME_STEP = 3'd6;

  // One ray request passed from the front end to the trig back end
  typedef struct packed {
    logic [15:0] az_angle;
    logic [15:0] el_angle;
    logic [33:0] time_ns;
    logic [9:0]  col;
    logic [6:0]  ring;
    logic        last;
  } ray_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROT,
    BK_MULX,
    BK_MULY,
    BK_EMIT
  } back_state_t;

  // Arctangent table, 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Round a Q60 product to Q1.15 and saturate
  function automatic logic [15:0] sat_prod(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< 44)) >>> 45;
    if (t > 66'sd32767) begin
      return 16'h7fff;
    end else if (t < -66'sd32768) begin
      return 16'h8000;
    end else begin
      return t[15:0];
    end
  endfunction

  // Round a Q30 value to Q1.15 and saturate
  function automatic logic [15:0] sat_q30(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = (v + 33'sd16384) >>> 15;
    if (t > 33'sd32767) begin
      return 16'h7fff;
    end else if (t < -33'sd32768) begin
      return 16'h8000;
    end else begin
      return t[15:0];
    end
  endfunction

endpackage

// File: hdl/lrg_front.sv
// Front end: configuration registers, ray counters and angle formation.
`timescale 1ns / 1ps
module lrg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  input  logic              q_full,
  output logic              q_push,
  output lrg_pkg::ray_req_t q_wdata
);
  import lrg_pkg::*;

  logic [10:0] az_count_r;
  logic [7:0]  el_count_r;
  logic [15:0] az_start_r;
  logic [15:0] az_step_r;
  logic [15:0] el_min_r;
  logic [15:0] el_step_r;
  logic [23:0] time_step_r;
  logic [9:0]  col_r, col_nxt;
  logic [6:0]  ring_r, ring_nxt;

  logic [10:0] ncol;
  logic [7:0]  nring;
  logic [9:0]  col_cur;
  logic [6:0]  ring_cur;
  logic        col_last, ring_last;
  logic [25:0] az_prod;
  logic [22:0] el_prod;
  logic [33:0] time_prod;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_count_r  <= 11'd360;
      el_count_r  <= 8'd16;
      az_start_r  <= 16'd32768;
      az_step_r   <= 16'd182;
      el_min_r    <= 16'hf555;
      el_step_r   <= 16'd364;
      time_step_r <= 24'd277778;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AZ_COUNT:  az_count_r  <= cfg_data[10:0];
        CFG_EL_COUNT:  el_count_r  <= cfg_data[7:0];
        CFG_AZ_START:  az_start_r  <= cfg_data[15:0];
        CFG_AZ_STEP:   az_step_r   <= cfg_data[15:0];
        CFG_EL_MIN:    el_min_r    <= cfg_data[15:0];
        CFG_EL_STEP:   el_step_r   <= cfg_data[15:0];
        CFG_TIME_STEP: time_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp counts to the supported range
  always_comb begin
    if (az_count_r == 11'd0) begin
      ncol = 11'd1;
    end else if (az_count_r > AZ_COUNT_MAX) begin
      ncol = AZ_COUNT_MAX;
    end else begin
      ncol = az_count_r;
    end
    if (el_count_r == 8'd0) begin
      nring = 8'd1;
    end else if (el_count_r > EL_COUNT_MAX) begin
      nring = EL_COUNT_MAX;
    end else begin
      nring = el_count_r;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign col_cur  = in_restart ? 10'd0 : col_r;
  assign ring_cur = in_restart ? 7'd0 : ring_r;

  assign col_last  = ({1'b0, col_cur} + 11'd1) >= ncol;
  assign ring_last = ({1'b0, ring_cur} + 8'd1) >= nring;

  assign az_prod   = col_cur * az_step_r;
  assign el_prod   = ring_cur * el_step_r;
  assign time_prod = col_cur * time_step_r;

  // Form the request for the back end
  always_comb begin
    q_wdata.az_angle = az_start_r + az_prod[15:0];
    q_wdata.el_angle = el_min_r + el_prod[15:0];
    q_wdata.time_ns  = time_prod;
    q_wdata.col      = col_cur;
    q_wdata.ring     = ring_cur;
    q_wdata.last     = col_last && ring_last;
  end

  // Advance ring first, column on ring wrap
  always_comb begin
    col_nxt  = col_cur;
    ring_nxt = ring_cur + 7'd1;
    if (ring_last) begin
      ring_nxt = 7'd0;
      col_nxt  = col_last ? 10'd0 : col_cur + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 10'd0;
      ring_r <= 7'd0;
    end else if (q_push) begin
      col_r  <= col_nxt;
      ring_r <= ring_nxt;
    end
  end

endmodule

// File: hdl/lrg_queue.sv
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
module lrg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lrg_pkg::ray_req_t wdata,
  input  logic              pop,
  output lrg_pkg::ray_req_t rdata,
  output logic              full,
  output logic              empty
);
  import lrg_pkg::*;

  ray_req_t    mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // Store pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: hdl/lrg_back.sv
// Back end: iterative CORDIC for both angles, products, rounding, output register.
`timescale 1ns / 1ps
module lrg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  lrg_pkg::ray_req_t q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_dir_x,
  output logic [15:0]       out_dir_y,
  output logic [15:0]       out_dir_z,
  output logic [33:0]       out_time_offset_ns,
  output logic [9:0]        out_column_index,
  output logic [6:0]        out_ring_index,
  output logic              out_frame_last
);
  import lrg_pkg::*;

  back_state_t state_r, state_nxt;
  logic [4:0]  iter_r;
  logic signed [32:0] ax_r, ay_r, ex_r, ey_r;
  logic signed [33:0] az_r, ez_r;
  logic        aflip_r, eflip_r;
  logic [33:0] time_r;
  logic [9:0]  col_r;
  logic [6:0]  ring_r;
  logic        last_r;
  logic signed [65:0] prod_r;
  logic [15:0] dir_x_r, dir_z_r;
  logic        out_valid_r;

  logic        load, out_free, emit;
  logic [31:0] aph, eph;
  logic        aflip, eflip;
  logic signed [33:0] atan_s;
  logic signed [32:0] caz, saz, cel, sel;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_ROT;
      BK_ROT:  if (iter_r == 5'(CORDIC_ITERS - 1)) state_nxt = BK_MULX;
      BK_MULX: state_nxt = BK_MULY;
      BK_MULY: state_nxt = BK_EMIT;
      BK_EMIT: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    case (state_r)
      BK_IDLE: load = !q_empty;
      BK_EMIT: emit = out_free;
      default: ;
    endcase
  end

  assign q_pop = load;

  // Fold angles into a half turn around zero
  always_comb begin
    aph   = {q_rdata.az_angle, 16'd0};
    eph   = {q_rdata.el_angle, 16'd0};
    aflip = aph[31] ^ aph[30];
    eflip = eph[31] ^ eph[30];
    aph[31] = aph[31] ^ aflip;
    eph[31] = eph[31] ^ eflip;
  end

  assign atan_s = {2'b00, atan_turn(iter_r)};

  assign caz = aflip_r ? -ax_r : ax_r;
  assign saz = aflip_r ? -ay_r : ay_r;
  assign cel = eflip_r ? -ex_r : ex_r;
  assign sel = eflip_r ? -ey_r : ey_r;

  // Rotate both vectors one step per cycle
  always_ff @(posedge clk) begin
    if (load) begin
      ax_r    <= CORDIC_GAIN;
      ay_r    <= 33'sd0;
      ex_r    <= CORDIC_GAIN;
      ey_r    <= 33'sd0;
      az_r    <= {{2{aph[31]}}, aph};
      ez_r    <= {{2{eph[31]}}, eph};
      aflip_r <= aflip;
      eflip_r <= eflip;
      iter_r  <= 5'd0;
      time_r  <= q_rdata.time_ns;
      col_r   <= q_rdata.col;
      ring_r  <= q_rdata.ring;
      last_r  <= q_rdata.last;
    end else if (state_r == BK_ROT) begin
      iter_r <= iter_r + 5'd1;
      if (!az_r[33]) begin
        ax_r <= ax_r - (ay_r >>> iter_r);
        ay_r <= ay_r + (ax_r >>> iter_r);
        az_r <= az_r - atan_s;
      end else begin
        ax_r <= ax_r + (ay_r >>> iter_r);
        ay_r <= ay_r - (ax_r >>> iter_r);
        az_r <= az_r + atan_s;
      end
      if (!ez_r[33]) begin
        ex_r <= ex_r - (ey_r >>> iter_r);
        ey_r <= ey_r + (ex_r >>> iter_r);
        ez_r <= ez_r - atan_s;
      end else begin
        ex_r <= ex_r + (ey_r >>> iter_r);
        ey_r <= ey_r - (ex_r >>> iter_r);
        ez_r <= ez_r + atan_s;
      end
    end
  end

  // Form products one per cycle and round
  always_ff @(posedge clk) begin
    case (state_r)
      BK_MULX: prod_r <= 66'(cel) * 66'(caz);
      BK_MULY: begin
        dir_x_r <= sat_prod(prod_r);
        dir_z_r <= sat_q30(sel);
        prod_r  <= 66'(cel) * 66'(saz);
      end
      default: ;
    endcase
  end

  // Load output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_dir_x          <= dir_x_r;
      out_dir_y          <= sat_prod(prod_r);
      out_dir_z          <= dir_z_r;
      out_time_offset_ns <= time_r;
      out_column_index   <= col_r;
      out_ring_index     <= ring_r;
      out_frame_last     <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/lidar_ray_grid_generator.sv
// Top level of the ray grid generator: front end, request queue, trig back end.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_restart
//   out_      output     out_valid/out_stall  dir_x/y/z, time, indices, frame_last
//   cfg_      input      cfg_we               cfg_index, cfg_data
//
// In the back end each ray is loaded, goes through 30 CORDIC rotations on
// two angle units, one per angle, then the two multiply states and the load of
// the output register; the rotation loop sets the rate, one ray at a time.
// Reset restores the default registers, zeroes the counters and empties the queue.
// The front takes requests while the two-entry queue has room; a stalled
// output holds its register and the back end waits with the next result.
`timescale 1ns / 1ps
module lidar_ray_grid_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_dir_x,
  output logic [15:0] out_dir_y,
  output logic [15:0] out_dir_z,
  output logic [33:0] out_time_offset_ns,
  output logic [9:0]  out_column_index,
  output logic [6:0]  out_ring_index,
  output logic        out_frame_last
);
  import lrg_pkg::*;

  ray_req_t q_wdata, q_rdata;
  logic     q_push, q_pop, q_full, q_empty;

  lrg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  lrg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lrg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_dir_x          (out_dir_x),
    .out_dir_y          (out_dir_y),
    .out_dir_z          (out_dir_z),
    .out_time_offset_ns (out_time_offset_ns),
    .out_column_index   (out_column_index),
    .out_ring_index     (out_ring_index),
    .out_frame_last     (out_frame_last)
  );

endmodule
